// File: rtl/core/bracket_nesting_checker_top_macros.svh
`ifndef BRACKET_NESTING_CHECKER_TOP_MACROS_SVH
`define BRACKET_NESTING_CHECKER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define BNC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define BNC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/bnc_pkg.sv
package bnc_pkg;

  localparam int unsigned StackDepth = 1024;
  localparam int unsigned AddrW      = $clog2(StackDepth);
  localparam int unsigned LevelW     = $clog2(StackDepth + 1);

  typedef enum logic [2:0] {
    StOk         = 3'd0,
    StEmpty      = 3'd1,
    StOdd        = 3'd2,
    StMismatch   = 3'd3,
    StCloseEmpty = 3'd4,
    StUnclosed   = 3'd5,
    StOverflow   = 3'd6
  } status_e;

  localparam logic [1:0] KindParen   = 2'd0;
  localparam logic [1:0] KindBrace   = 2'd1;
  localparam logic [1:0] KindBracket = 2'd2;
  localparam logic [1:0] KindAngle   = 2'd3;

  localparam logic [7:0] ChParenOpen    = 8'h28;
  localparam logic [7:0] ChParenClose   = 8'h29;
  localparam logic [7:0] ChBraceOpen    = 8'h7b;
  localparam logic [7:0] ChBraceClose   = 8'h7d;
  localparam logic [7:0] ChBracketOpen  = 8'h5b;
  localparam logic [7:0] ChBracketClose = 8'h5d;
  localparam logic [7:0] ChAngleOpen    = 8'h3c;
  localparam logic [7:0] ChAngleClose   = 8'h3e;

  typedef struct packed {
    logic       hit;
    logic [1:0] kind;
  } bracket_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [1:0]       wdata;
    logic [AddrW-1:0] raddr;
  } stack_req_t;

  function automatic bracket_t opener_decode(logic [7:0] ch, logic ext);
    bracket_t res;
    res.hit  = 1'b1;
    res.kind = KindParen;
    if (ch == ChParenOpen) begin
      res.kind = KindParen;
    end else if (ch == ChBraceOpen) begin
      res.kind = KindBrace;
    end else if (ch == ChBracketOpen) begin
      res.kind = KindBracket;
    end else if (ext && ch == ChAngleOpen) begin
      res.kind = KindAngle;
    end else begin
      res.hit = 1'b0;
    end
    return res;
  endfunction

  function automatic bracket_t closer_decode(logic [7:0] ch, logic ext);
    bracket_t res;
    res.hit  = 1'b1;
    res.kind = KindParen;
    if (ch == ChParenClose) begin
      res.kind = KindParen;
    end else if (ch == ChBraceClose) begin
      res.kind = KindBrace;
    end else if (ch == ChBracketClose) begin
      res.kind = KindBracket;
    end else if (ext && ch == ChAngleClose) begin
      res.kind = KindAngle;
    end else begin
      res.hit = 1'b0;
    end
    return res;
  endfunction

endpackage

// File: rtl/core/bnc_stack_ram.sv
module bnc_stack_ram
  import bnc_pkg::*;
(
  input  logic       clk_i,
  input  stack_req_t req_i,
  output logic [1:0] rdata_o
);

  logic [1:0] mem_q [StackDepth];
  logic [1:0] rdata_q;

  // write-first: a read of the entry written in the same cycle sees the new value
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.we && (req_i.waddr == req_i.raddr)) begin
      rdata_q <= req_i.wdata;
    end else begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/bracket_nesting_checker_top.sv
// Bracket nesting checker: takes one byte of a string per word and checks that its brackets
// are properly nested, giving one verdict word (ok flag and status code) for each word that
// carries tlast. A new word is taken in every cycle as long as the result side keeps up; the
// verdict is registered and appears in the cycle after the last word is accepted. The top
// opener lives in a register and the entry below it is prefetched from the stack memory (one
// write and one read port, registered read data), so back-to-back pushes and pops run at full
// rate. The memory needs no clearing after reset. Writes to mode take effect from the next byte.
`include "bracket_nesting_checker_top_macros.svh"

module bracket_nesting_checker_top
  import bnc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,    // mode
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i, // [7:0] ch
  input  logic       s_axis_tuser_i, // [0] has_char
  input  logic       s_axis_tlast_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o  // [0] valid_res, [3:1] status, [7:4] zero
);

  logic              mode_q;
  logic [LevelW-1:0] level_q, level_d;
  logic [1:0]        tos_q, tos_d;
  status_e           fail_q, fail_d;
  logic              parity_q, parity_d;
  logic              seen_q, seen_d;
  logic              out_valid_q;
  logic              res_ok_q;
  status_e           res_status_q;
  status_e           status;
  logic              s_acc;
  logic              push;
  bracket_t          op;
  bracket_t          cl;
  stack_req_t        req;
  logic [1:0]        below;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign op              = opener_decode(s_axis_tdata_i, mode_q);
  assign cl              = closer_decode(s_axis_tdata_i, mode_q);

  bnc_stack_ram u_stack (
    .clk_i  (clk_i),
    .req_i  (req),
    .rdata_o(below)
  );

  always_comb begin
    level_d   = level_q;
    tos_d     = tos_q;
    fail_d    = fail_q;
    parity_d  = parity_q;
    seen_d    = seen_q;
    push      = 1'b0;
    req.we    = 1'b0;
    req.waddr = AddrW'(level_q - LevelW'(1));
    req.wdata = tos_q;

    if (s_acc && s_axis_tuser_i) begin
      seen_d   = 1'b1;
      parity_d = !parity_q;
      if (fail_q == StOk) begin
        if (op.hit) begin
          if (level_q == LevelW'(StackDepth)) begin
            fail_d = StOverflow;
          end else begin
            // old top moves into memory
            push    = 1'b1;
            req.we  = (level_q != '0);
            tos_d   = op.kind;
            level_d = level_q + LevelW'(1);
          end
        end else if (!mode_q || cl.hit) begin
          if (level_q == '0) begin
            fail_d = StCloseEmpty;
          end else if (!cl.hit || tos_q != cl.kind) begin
            fail_d = StMismatch;
          end else begin
            tos_d   = below;
            level_d = level_q - LevelW'(1);
          end
        end
      end
    end

    if (!seen_d) begin
      status = StEmpty;
    end else if (parity_d) begin
      status = StOdd;
    end else if (fail_d != StOk) begin
      status = fail_d;
    end else if (level_d != '0) begin
      status = StUnclosed;
    end else begin
      status = StOk;
    end

    if (s_acc && s_axis_tlast_i) begin
      level_d  = '0;
      fail_d   = StOk;
      parity_d = 1'b0;
      seen_d   = 1'b0;
    end

    // prefetch the entry just below the next top
    req.raddr = AddrW'(level_d - LevelW'(2));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      level_q     <= '0;
      fail_q      <= StOk;
      parity_q    <= 1'b0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      level_q  <= level_d;
      fail_q   <= fail_d;
      parity_q <= parity_d;
      seen_q   <= seen_d;
      if (s_acc && s_axis_tlast_i) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tos_q <= tos_d;
    if (s_acc && s_axis_tlast_i) begin
      res_ok_q     <= (status == StOk);
      res_status_q <= status;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, res_status_q, res_ok_q};

  `BNC_ASSERT_NOW(a_level_bound, 1'b1, level_q <= LevelW'(StackDepth), "stack level overrun")
  `BNC_ASSERT_NOW(a_verdict_flag, out_valid_q, res_ok_q == (res_status_q == StOk), "verdict mismatch")
  `BNC_ASSERT_NEXT(a_fail_sticky, s_acc && !s_axis_tlast_i && fail_q != StOk, fail_q == $past(fail_q), "held failure changed")
  `BNC_ASSERT_NEXT(a_push_top, s_acc && push && !s_axis_tlast_i, tos_q == $past(op.kind), "pushed opener not on top")

endmodule
